[hw/rtl/snp83_pkg.sv]
// Shared types and constants for the 8.3 short-name parser.
// Used by the character classifier, the name builder and the top level.
package snp83_pkg;

    localparam int unsigned BASE_LEN = 8;
    localparam int unsigned EXT_LEN  = 3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam int unsigned BASE_W = 8 * BASE_LEN;
    localparam int unsigned EXT_W  = 8 * EXT_LEN;
    localparam int unsigned RES_W  = BASE_W + EXT_W + 1;
    localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef logic [7:0] byte_t;

    // Decoded view of one path byte.
    typedef struct packed {
        logic  is_term;
        logic  is_slash;
        logic  is_dot;
        logic  forbidden;
        byte_t up;
    } char_info_t;

endpackage

[hw/rtl/snp83_char_class.sv]
// Classifies one path byte: terminator, slash, dot, forbidden, upper-cased value.
// Depends on snp83_pkg.
module snp83_char_class (
    input  snp83_pkg::byte_t      ch,
    output snp83_pkg::char_info_t info
);
    import snp83_pkg::*;

    byte_t up;

    always_comb begin
        up = ch;
        if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
            up = ch - CASE_OFS;
        end
    end

    always_comb begin
        info.is_term  = (ch == CH_NUL);
        info.is_slash = (ch == CH_SLASH);
        info.is_dot   = (ch == CH_DOT);
        info.up       = up;
        info.forbidden = (up <= CH_SPACE) ||
                         (up inside {8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B,
                                     8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D,
                                     8'h7C});
    end

endmodule

[hw/rtl/snp83_name_build.sv]
// Name state (leading flag, extension flag, counts, buffers) and the result register.
// Depends on snp83_pkg.
module snp83_name_build (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step,
    input  snp83_pkg::char_info_t                 info,
    input  logic                                  res_take,
    output logic                                  res_valid,
    output logic [snp83_pkg::BASE_W-1:0]          res_base,
    output logic [snp83_pkg::EXT_W-1:0]           res_ext,
    output logic                                  res_ok
);
    import snp83_pkg::*;

    logic        leading_reg, leading_next;
    logic        in_ext_reg, in_ext_next;
    logic [3:0]  base_count_reg, base_count_next;
    logic [1:0]  ext_count_reg, ext_count_next;
    logic        bad_reg, bad_next;
    byte_t       base_buf_reg [BASE_LEN];
    byte_t       base_buf_next [BASE_LEN];
    byte_t       ext_buf_reg [EXT_LEN];
    byte_t       ext_buf_next [EXT_LEN];

    logic                 out_valid_reg, out_valid_next;
    logic [BASE_W-1:0]    out_base_reg, out_base_next;
    logic [EXT_W-1:0]     out_ext_reg, out_ext_next;
    logic                 out_ok_reg, out_ok_next;

    logic                 ok;
    logic [BASE_W-1:0]    packed_base;
    logic [EXT_W-1:0]     packed_ext;

    // First buffered byte lands in the top bits.
    always_comb begin
        for (int i = 0; i < BASE_LEN; i++) begin
            packed_base[BASE_W-1-8*i -: 8] = base_buf_reg[i];
        end
        for (int i = 0; i < EXT_LEN; i++) begin
            packed_ext[EXT_W-1-8*i -: 8] = ext_buf_reg[i];
        end
    end

    assign ok = !bad_reg && (base_count_reg != 4'd0);

    always_comb begin
        leading_next    = leading_reg;
        in_ext_next     = in_ext_reg;
        base_count_next = base_count_reg;
        ext_count_next  = ext_count_reg;
        bad_next        = bad_reg;
        base_buf_next   = base_buf_reg;
        ext_buf_next    = ext_buf_reg;
        out_valid_next  = out_valid_reg && !res_take;
        out_base_next   = out_base_reg;
        out_ext_next    = out_ext_reg;
        out_ok_next     = out_ok_reg;

        if (step) begin
            if (info.is_term) begin
                out_valid_next  = 1'b1;
                out_ok_next     = ok;
                out_base_next   = ok ? packed_base : '0;
                out_ext_next    = ok ? packed_ext : '0;
                leading_next    = 1'b1;
                in_ext_next     = 1'b0;
                base_count_next = 4'd0;
                ext_count_next  = 2'd0;
                bad_next        = 1'b0;
                for (int i = 0; i < BASE_LEN; i++) base_buf_next[i] = CH_SPACE;
                for (int i = 0; i < EXT_LEN; i++) ext_buf_next[i] = CH_SPACE;
            end else if (!bad_reg && !(leading_reg && info.is_slash)) begin
                leading_next = 1'b0;
                if (info.is_dot) begin
                    if (in_ext_reg) begin
                        bad_next = 1'b1;
                    end else begin
                        in_ext_next = 1'b1;
                    end
                end else if (info.forbidden) begin
                    bad_next = 1'b1;
                end else if (!in_ext_reg) begin
                    if (base_count_reg >= 4'(BASE_LEN)) begin
                        bad_next = 1'b1;
                    end else begin
                        base_buf_next[base_count_reg[2:0]] = info.up;
                        base_count_next = base_count_reg + 4'd1;
                    end
                end else begin
                    if (ext_count_reg >= 2'(EXT_LEN)) begin
                        bad_next = 1'b1;
                    end else begin
                        ext_buf_next[ext_count_reg] = info.up;
                        ext_count_next = ext_count_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leading_reg    <= 1'b1;
            in_ext_reg     <= 1'b0;
            base_count_reg <= 4'd0;
            ext_count_reg  <= 2'd0;
            bad_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < BASE_LEN; i++) base_buf_reg[i] <= CH_SPACE;
            for (int i = 0; i < EXT_LEN; i++) ext_buf_reg[i] <= CH_SPACE;
        end else begin
            leading_reg    <= leading_next;
            in_ext_reg     <= in_ext_next;
            base_count_reg <= base_count_next;
            ext_count_reg  <= ext_count_next;
            bad_reg        <= bad_next;
            out_valid_reg  <= out_valid_next;
            base_buf_reg   <= base_buf_next;
            ext_buf_reg    <= ext_buf_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_base_reg <= out_base_next;
        out_ext_reg  <= out_ext_next;
        out_ok_reg   <= out_ok_next;
    end

    assign res_valid = out_valid_reg;
    assign res_base  = out_base_reg;
    assign res_ext   = out_ext_reg;
    assign res_ok    = out_ok_reg;

endmodule

[hw/rtl/short_name_parser_8_3_core.sv]
// 8.3 short-name parser. Path bytes come in one item per clock on the s_ stream,
// ending with a zero byte; each zero byte yields one result item on the m_ stream
// holding the space-padded base and extension and a valid flag (fields zero when
// invalid). After the edge that accepts a terminator, the byte sits in the input register;
// once the result register is free it steps, updating the name and loading the result
// register, which raises m_tvalid. The block sustains one byte per clock; only a result still
// waiting at the output holds back the next terminator, and the bytes behind it.
// Depends on snp83_pkg, snp83_char_class and snp83_name_build.
module short_name_parser_8_3_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [7:0] ch
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [snp83_pkg::TDATA_W-1:0]      m_tdata   // [63:0] base_name,
                                                         // [87:64] ext_name,
                                                         // [88] valid_res, rest 0
);
    import snp83_pkg::*;

    logic        in_valid_reg, in_valid_next;
    byte_t       in_ch_reg, in_ch_next;
    char_info_t  info;
    logic        step;
    logic        out_free;
    logic        res_valid;
    logic [BASE_W-1:0] res_base;
    logic [EXT_W-1:0]  res_ext;
    logic        res_ok;

    snp83_char_class u_class (
        .ch   (in_ch_reg),
        .info (info)
    );

    // A plain byte always advances; a terminator needs room in the result register.
    assign out_free = !res_valid || m_tready;
    assign step     = in_valid_reg && (!info.is_term || out_free);
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_ch_next    = in_ch_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_ch_next    = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_ch_reg <= in_ch_next;
    end

    snp83_name_build u_build (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .info      (info),
        .res_take  (m_tready),
        .res_valid (res_valid),
        .res_base  (res_base),
        .res_ext   (res_ext),
        .res_ok    (res_ok)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {(TDATA_W - RES_W)'(0), res_ok, res_ext, res_base};

endmodule

[sim/tb_short_name_parser_8_3_core.sv]
// Testbench for short_name_parser_8_3_core: streams path bytes, predicts each 8.3 name
// in its own model of the parser and checks every result item field by field.
// Depends on snp83_pkg and the parser RTL.
module tb_short_name_parser_8_3_core;
    import snp83_pkg::*;

    typedef struct packed {
        logic [63:0] base;
        logic [23:0] ext;
        logic        ok;
    } short_name_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // [7:0] ch
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;   // [63:0] base_name, [87:64] ext_name, [88] valid_res

    short_name_parser_8_3_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Parser state as predicted by the testbench.
    logic        nm_leading;
    logic        nm_in_ext;
    int unsigned nm_base_cnt;
    int unsigned nm_ext_cnt;
    logic        nm_bad;
    byte_t       nm_base [BASE_LEN];
    byte_t       nm_ext [EXT_LEN];

    short_name_t expected_names[$];
    byte_t       path_bytes[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          hold_cycles = 0;
    bit          tx_steady = 0;
    bit          rx_steady = 0;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic bit is_reserved(byte_t c);
        if (c <= CH_SPACE)
            return 1'b1;
        case (c)
            // " * + , / : ; < = > ? [ \ ] |
            8'h22, 8'h2A, 8'h2B, 8'h2C, CH_SLASH, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
            8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void clear_name();
        nm_leading  = 1'b1;
        nm_in_ext   = 1'b0;
        nm_base_cnt = 0;
        nm_ext_cnt  = 0;
        nm_bad      = 1'b0;
        foreach (nm_base[i]) nm_base[i] = CH_SPACE;
        foreach (nm_ext[i]) nm_ext[i] = CH_SPACE;
    endfunction

    function automatic void fold_path_byte(byte_t c);
        byte_t u;
        u = c;
        if (nm_bad)
            return;
        if (nm_leading) begin
            if (c == CH_SLASH)
                return;
            nm_leading = 1'b0;
        end
        // The dot test looks at the raw byte, before upper-casing.
        if (c == CH_DOT) begin
            if (nm_in_ext)
                nm_bad = 1'b1;
            else
                nm_in_ext = 1'b1;
            return;
        end
        if (c >= CH_LC_A && c <= CH_LC_Z)
            u = c - CASE_OFS;
        if (is_reserved(u)) begin
            nm_bad = 1'b1;
        end else if (!nm_in_ext) begin
            if (nm_base_cnt >= BASE_LEN) begin
                nm_bad = 1'b1;
            end else begin
                nm_base[nm_base_cnt] = u;
                nm_base_cnt++;
            end
        end else begin
            if (nm_ext_cnt >= EXT_LEN) begin
                nm_bad = 1'b1;
            end else begin
                nm_ext[nm_ext_cnt] = u;
                nm_ext_cnt++;
            end
        end
    endfunction

    function automatic void predict_name(byte_t c);
        short_name_t n;
        n = '0;
        if (c != CH_NUL) begin
            fold_path_byte(c);
            return;
        end
        n.ok = !nm_bad && (nm_base_cnt > 0);
        if (n.ok) begin
            foreach (nm_base[i]) n.base = {n.base[55:0], nm_base[i]};
            foreach (nm_ext[i]) n.ext = {n.ext[15:0], nm_ext[i]};
        end
        expected_names.push_back(n);
        clear_name();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // Offers one byte from a falling edge and returns at the falling edge after acceptance.
    task automatic send_char(input byte_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_name(c);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(byte_t'(s[i]));
        send_char(CH_NUL);
    endtask

    task automatic send_path();
        while (path_bytes.size() > 0)
            send_char(path_bytes.pop_front());
        send_char(CH_NUL);
    endtask

    function automatic byte_t legal_char();
        byte_t c;
        c = byte_t'($urandom_range(33, 255));
        while (is_reserved(c) || c == CH_DOT)
            c = byte_t'($urandom_range(33, 255));
        return c;
    endfunction

    function automatic byte_t reserved_char();
        byte_t c;
        c = byte_t'($urandom_range(1, 127));
        while (!is_reserved(c))
            c = byte_t'($urandom_range(1, 127));
        return c;
    endfunction

    function automatic void add_legal(int n);
        repeat (n) path_bytes.push_back(legal_char());
    endfunction

    function automatic void build_good_path();
        repeat ($urandom_range(0, 2)) path_bytes.push_back(CH_SLASH);
        add_legal($urandom_range(1, BASE_LEN));
        if ($urandom_range(0, 3) != 0) begin
            path_bytes.push_back(CH_DOT);
            add_legal($urandom_range(0, EXT_LEN));
        end
    endfunction

    function automatic void build_bad_path();
        case ($urandom_range(0, 5))
            0: add_legal($urandom_range(BASE_LEN + 1, BASE_LEN + 4));
            1: begin
                add_legal($urandom_range(1, BASE_LEN));
                path_bytes.push_back(CH_DOT);
                add_legal($urandom_range(EXT_LEN + 1, EXT_LEN + 3));
            end
            2: begin
                build_good_path();
                path_bytes.insert($urandom_range(0, path_bytes.size()), reserved_char());
            end
            3: begin
                add_legal($urandom_range(1, 4));
                path_bytes.push_back(CH_DOT);
                add_legal($urandom_range(0, 2));
                path_bytes.push_back(CH_DOT);
                add_legal($urandom_range(0, 2));
            end
            4: begin
                add_legal($urandom_range(1, 4));
                path_bytes.push_back(CH_SLASH);
                add_legal($urandom_range(1, 4));
            end
            default: begin
                // Nothing but slashes, possibly followed by a bare extension.
                repeat ($urandom_range(0, 3)) path_bytes.push_back(CH_SLASH);
                if ($urandom_range(0, 1)) begin
                    path_bytes.push_back(CH_DOT);
                    add_legal($urandom_range(0, EXT_LEN));
                end
            end
        endcase
    endfunction

    task automatic test_empty_names();
        send_char(CH_NUL);
        send_text("//");
        send_text(".ab");
    endtask

    task automatic test_legal_names();
        send_text("/a.b");
        send_char(8'hFF);
        send_char(8'h80);
        send_char(CH_NUL);
    endtask

    task automatic test_invalid_names();
        // A control byte spoils the name; the byte after it is ignored.
        send_char(byte_t'("x"));
        send_char(8'h01);
        send_text("z");
        send_text("a..b");
    endtask

    task automatic test_output_stall();
        tx_steady = 1'b1;
        hold_cycles = 300;
        repeat (30) begin
            build_good_path();
            send_path();
        end
        tx_steady = 1'b0;
    endtask

    task automatic test_random_names();
        int names;
        int r;
        names = 0;
        while (items_sent < 1350) begin
            if (names % 16 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 65)
                build_good_path();
            else if (r < 85)
                build_bad_path();
            else
                repeat ($urandom_range(0, 12)) path_bytes.push_back(byte_t'($urandom_range(1, 255)));
            send_path();
            names++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Result side: random stalls, mostly short, and a long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (rx_steady || $urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
            end
        end
    end

    always @(posedge aclk) begin
        short_name_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_names.size() == 0) begin
                $error("unexpected result item: base_name %h ext_name %h valid_res %b",
                       m_tdata[63:0], m_tdata[87:64], m_tdata[88]);
                fail_count++;
            end else begin
                want = expected_names.pop_front();
                if (m_tdata[63:0] !== want.base) begin
                    $error("base_name: expected %h, got %h", want.base, m_tdata[63:0]);
                    fail_count++;
                end
                if (m_tdata[87:64] !== want.ext) begin
                    $error("ext_name: expected %h, got %h", want.ext, m_tdata[87:64]);
                    fail_count++;
                end
                if (m_tdata[88] !== want.ok) begin
                    $error("valid_res: expected %b, got %b", want.ok, m_tdata[88]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        clear_name();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_names();
        test_legal_names();
        test_invalid_names();
        test_output_stall();
        test_random_names();
        s_tvalid <= 1'b0;

        while (expected_names.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/snp83_pkg.sv
hw/rtl/snp83_char_class.sv
hw/rtl/snp83_name_build.sv
hw/rtl/short_name_parser_8_3_core.sv
sim/tb_short_name_parser_8_3_core.sv
